// ===== sv/rft_pkg.sv =====
`default_nettype none

package rft_pkg;

    localparam int USER_W  = 3;
    localparam int INODE_W = 8;
    localparam int COUNT_W = 7;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

    localparam logic KIND_OPEN  = 1'b0;
    localparam logic KIND_CLOSE = 1'b1;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_USER_FULL = 2'd1;
    localparam logic [1:0] STAT_SYS_FULL  = 2'd2;
    localparam logic [1:0] STAT_NOT_OPEN  = 2'd3;

    typedef struct packed {
        logic               kind;
        logic [USER_W-1:0]  user;
        logic [INODE_W-1:0] inode;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         sys_index;
        logic [2:0]         user_slot;
        logic [COUNT_W-1:0] ref_count;
        logic [3:0]         user_open_count;
        logic [4:0]         sys_open_count;
    } rsp_t;

    typedef struct packed {
        logic               valid;
        logic [INODE_W-1:0] inode;
        logic [COUNT_W-1:0] count;
    } sys_ent_t;

endpackage

`default_nettype wire

// ===== sv/rft_tables.sv =====
`default_nettype none

module rft_tables
    import rft_pkg::*;
#(
    parameter int UENT      = 64,
    parameter int SYS_SLOTS = 16,
    parameter int UADDR_W   = 6,
    parameter int SIDX_W    = 4
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    output logic                    ready,
    input  wire logic [UADDR_W-1:0] u_rd_addr,
    output logic                    u_rd_valid,
    output logic [SIDX_W-1:0]       u_rd_sidx,
    input  wire logic               u_wr_en,
    input  wire logic [UADDR_W-1:0] u_wr_addr,
    input  wire logic               u_wr_valid,
    input  wire logic [SIDX_W-1:0]  u_wr_sidx,
    input  wire logic [SIDX_W-1:0]  s_rd_addr,
    output sys_ent_t                s_rd_data,
    input  wire logic               s_wr_en,
    input  wire logic [SIDX_W-1:0]  s_wr_addr,
    input  wire sys_ent_t           s_wr_data
);

    localparam int CLR_N = (UENT > SYS_SLOTS) ? UENT : SYS_SLOTS;
    localparam int CLR_W = $clog2(CLR_N + 1);

    logic [CLR_W-1:0] clr_cnt_reg;
    logic             clearing;

    logic [SIDX_W:0]  u_mem [UENT];
    logic [SIDX_W:0]  u_rd_q;
    sys_ent_t         s_mem [SYS_SLOTS];
    sys_ent_t         s_rd_q;

    assign clearing = clr_cnt_reg < CLR_W'(CLR_N);
    assign ready    = !clearing;

    // one entry of each memory cleared per cycle after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (clearing)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            if (clr_cnt_reg < CLR_W'(UENT))
            begin
                u_mem[UADDR_W'(clr_cnt_reg)] <= '0;
            end
        end
        else if (u_wr_en)
        begin
            u_mem[u_wr_addr] <= {u_wr_valid, u_wr_sidx};
        end
        u_rd_q <= u_mem[u_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            if (clr_cnt_reg < CLR_W'(SYS_SLOTS))
            begin
                s_mem[SIDX_W'(clr_cnt_reg)] <= '0;
            end
        end
        else if (s_wr_en)
        begin
            s_mem[s_wr_addr] <= s_wr_data;
        end
        s_rd_q <= s_mem[s_rd_addr];
    end

    assign u_rd_valid = u_rd_q[SIDX_W];
    assign u_rd_sidx  = u_rd_q[SIDX_W-1:0];
    assign s_rd_data  = s_rd_q;

endmodule

`default_nettype wire

// ===== sv/refcounted_open_file_table_core.sv =====
// open: a scan of the user's slots, then a scan of the system table, then done
// close: the user slot scan alone; open with the user table full: the user slot scan alone
// a request from an absent user: done follows in the cycle after start
// one item at a time; the rate is set by the slot scan, one memory read per cycle
// after reset busy stays high through a clearing pass over every entry of both tables
// and until the core then enters idle; done pulses, the receiver cannot stall
`default_nettype none

module refcounted_open_file_table_core
    import rft_pkg::*;
#(
    parameter int USERS      = 8,
    parameter int USER_SLOTS = 8,
    parameter int SYS_SLOTS  = 16,
    parameter int INODES     = 256
)(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire req_t req,
    output logic      done,
    output rsp_t      rsp
);

    localparam int UENT    = USERS * USER_SLOTS;
    localparam int UADDR_W = (UENT > 1) ? $clog2(UENT) : 1;
    localparam int SIDX_W  = (SYS_SLOTS > 1) ? $clog2(SYS_SLOTS) : 1;
    localparam int SLOT_W  = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;
    localparam int UCNT_W  = $clog2(USER_SLOTS + 1);
    localparam int SCNT_W  = $clog2(SYS_SLOTS + 1);
    localparam int MAXN    = (USER_SLOTS > SYS_SLOTS) ? USER_SLOTS : SYS_SLOTS;
    localparam int ISS_W   = $clog2(MAXN + 1);

    localparam logic [6:0]  USERS_V  = 7'(USERS);
    localparam logic [16:0] INODES_V = 17'(INODES);

    localparam logic [1:0] ST_INIT  = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_USCAN = 2'd2;
    localparam logic [1:0] ST_SSCAN = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic               kind_reg, kind_next;
    logic [INODE_W-1:0] inode_reg, inode_next;
    logic [UADDR_W-1:0] ubase_reg, ubase_next;
    logic [ISS_W-1:0]   iss_reg, iss_next;
    logic               p1_vld_reg, p1_vld_next;
    logic [ISS_W-1:0]   p1_idx_reg, p1_idx_next;
    logic               p2_vld_reg, p2_vld_next;
    logic [SLOT_W-1:0]  p2_slot_reg, p2_slot_next;
    logic               p2_uvalid_reg, p2_uvalid_next;
    logic [UCNT_W-1:0]  vcnt_reg, vcnt_next;
    logic               ufree_reg, ufree_next;
    logic [SLOT_W-1:0]  ufree_slot_reg, ufree_slot_next;
    logic               hit_reg, hit_next;
    logic [SLOT_W-1:0]  hit_slot_reg, hit_slot_next;
    logic [SIDX_W-1:0]  hit_e_reg, hit_e_next;
    logic [COUNT_W-1:0] hit_cnt_reg, hit_cnt_next;
    logic               smatch_reg, smatch_next;
    logic [SIDX_W-1:0]  smatch_idx_reg, smatch_idx_next;
    logic [COUNT_W-1:0] smatch_cnt_reg, smatch_cnt_next;
    logic               sfree_reg, sfree_next;
    logic [SIDX_W-1:0]  sfree_idx_reg, sfree_idx_next;
    logic [SCNT_W-1:0]  scnt_reg, scnt_next;
    logic               done_reg, done_next;
    rsp_t               rsp_reg, rsp_next;

    // entry index that the close lookup read in the previous cycle
    logic [SIDX_W-1:0]  s_rd_addr_q;

    logic               tbl_ready;
    logic [UADDR_W-1:0] u_rd_addr;
    logic               u_rd_valid;
    logic [SIDX_W-1:0]  u_rd_sidx;
    logic               u_wr_en;
    logic [UADDR_W-1:0] u_wr_addr;
    logic               u_wr_valid;
    logic [SIDX_W-1:0]  u_wr_sidx;
    logic [SIDX_W-1:0]  s_rd_addr;
    sys_ent_t           s_rd_data;
    logic               s_wr_en;
    logic [SIDX_W-1:0]  s_wr_addr;
    sys_ent_t           s_wr_data;

    logic               ino_ok;
    logic               iss_more;
    logic [ISS_W-1:0]   iss_lim;

    rft_tables #(
        .UENT      (UENT),
        .SYS_SLOTS (SYS_SLOTS),
        .UADDR_W   (UADDR_W),
        .SIDX_W    (SIDX_W)
    ) u_tables (
        .clk        (clk),
        .rst_n      (rst_n),
        .ready      (tbl_ready),
        .u_rd_addr  (u_rd_addr),
        .u_rd_valid (u_rd_valid),
        .u_rd_sidx  (u_rd_sidx),
        .u_wr_en    (u_wr_en),
        .u_wr_addr  (u_wr_addr),
        .u_wr_valid (u_wr_valid),
        .u_wr_sidx  (u_wr_sidx),
        .s_rd_addr  (s_rd_addr),
        .s_rd_data  (s_rd_data),
        .s_wr_en    (s_wr_en),
        .s_wr_addr  (s_wr_addr),
        .s_wr_data  (s_wr_data)
    );

    assign ino_ok   = {9'd0, inode_reg} < INODES_V;
    assign iss_lim  = (state_reg == ST_SSCAN) ? ISS_W'(SYS_SLOTS) : ISS_W'(USER_SLOTS);
    assign iss_more = iss_reg < iss_lim;

    assign u_rd_addr = ubase_reg + UADDR_W'(iss_reg);
    // user scan on close looks up the entry each slot points at
    assign s_rd_addr = (state_reg == ST_SSCAN) ? SIDX_W'(iss_reg) : u_rd_sidx;

    always_comb
    begin
        logic [COUNT_W-1:0] new_cnt;
        logic [SIDX_W-1:0]  tgt_idx;

        new_cnt         = '0;
        tgt_idx         = '0;
        state_next      = state_reg;
        kind_next       = kind_reg;
        inode_next      = inode_reg;
        ubase_next      = ubase_reg;
        iss_next        = iss_reg;
        p1_vld_next     = 1'b0;
        p1_idx_next     = iss_reg;
        p2_vld_next     = 1'b0;
        p2_slot_next    = SLOT_W'(p1_idx_reg);
        p2_uvalid_next  = u_rd_valid;
        vcnt_next       = vcnt_reg;
        ufree_next      = ufree_reg;
        ufree_slot_next = ufree_slot_reg;
        hit_next        = hit_reg;
        hit_slot_next   = hit_slot_reg;
        hit_e_next      = hit_e_reg;
        hit_cnt_next    = hit_cnt_reg;
        smatch_next     = smatch_reg;
        smatch_idx_next = smatch_idx_reg;
        smatch_cnt_next = smatch_cnt_reg;
        sfree_next      = sfree_reg;
        sfree_idx_next  = sfree_idx_reg;
        scnt_next       = scnt_reg;
        done_next       = 1'b0;
        rsp_next        = rsp_reg;
        u_wr_en         = 1'b0;
        u_wr_addr       = ubase_reg;
        u_wr_valid      = 1'b0;
        u_wr_sidx       = '0;
        s_wr_en         = 1'b0;
        s_wr_addr       = '0;
        s_wr_data       = '0;

        case (state_reg)
            ST_INIT:
            begin
                if (tbl_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next   = req.kind;
                    inode_next  = req.inode;
                    ubase_next  = UADDR_W'(req.user) * UADDR_W'(USER_SLOTS);
                    iss_next    = '0;
                    vcnt_next   = '0;
                    ufree_next  = 1'b0;
                    hit_next    = 1'b0;
                    smatch_next = 1'b0;
                    sfree_next  = 1'b0;
                    if ({4'd0, req.user} < USERS_V)
                    begin
                        state_next = ST_USCAN;
                    end
                    else
                    begin
                        // user without a table
                        done_next                = 1'b1;
                        rsp_next.status          = (req.kind == KIND_OPEN) ?
                                                   STAT_USER_FULL : STAT_NOT_OPEN;
                        rsp_next.sys_index       = '0;
                        rsp_next.user_slot       = '0;
                        rsp_next.ref_count       = '0;
                        rsp_next.user_open_count = '0;
                        rsp_next.sys_open_count  = 5'(scnt_reg);
                    end
                end
            end

            ST_USCAN:
            begin
                if (iss_more)
                begin
                    p1_vld_next = 1'b1;
                    iss_next    = iss_reg + 1'b1;
                end
                if (p1_vld_reg)
                begin
                    if (kind_reg == KIND_OPEN)
                    begin
                        vcnt_next = vcnt_reg + UCNT_W'(u_rd_valid);
                        if (!u_rd_valid && !ufree_reg)
                        begin
                            ufree_next      = 1'b1;
                            ufree_slot_next = SLOT_W'(p1_idx_reg);
                        end
                    end
                    else
                    begin
                        p2_vld_next = 1'b1;
                    end
                end
                if (p2_vld_reg)
                begin
                    vcnt_next = vcnt_reg + UCNT_W'(p2_uvalid_reg);
                    if (p2_uvalid_reg && s_rd_data.valid && s_rd_data.inode == inode_reg &&
                        ino_ok && !hit_reg)
                    begin
                        hit_next      = 1'b1;
                        hit_slot_next = p2_slot_reg;
                        hit_e_next    = SIDX_W'(s_rd_addr_q);
                        hit_cnt_next  = s_rd_data.count;
                    end
                end
                if (!iss_more && !p1_vld_reg && !p2_vld_reg)
                begin
                    rsp_next.sys_index       = '0;
                    rsp_next.user_slot       = '0;
                    rsp_next.ref_count       = '0;
                    rsp_next.user_open_count = 4'(vcnt_reg);
                    rsp_next.sys_open_count  = 5'(scnt_reg);
                    if (kind_reg == KIND_OPEN)
                    begin
                        if (!ufree_reg)
                        begin
                            done_next       = 1'b1;
                            state_next      = ST_IDLE;
                            rsp_next.status = STAT_USER_FULL;
                        end
                        else if (!ino_ok)
                        begin
                            done_next       = 1'b1;
                            state_next      = ST_IDLE;
                            rsp_next.status = STAT_SYS_FULL;
                        end
                        else
                        begin
                            iss_next   = '0;
                            state_next = ST_SSCAN;
                        end
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                        if (hit_reg)
                        begin
                            new_cnt    = (hit_cnt_reg != '0) ? hit_cnt_reg - 1'b1 : '0;
                            u_wr_en    = 1'b1;
                            u_wr_addr  = ubase_reg + UADDR_W'(hit_slot_reg);
                            s_wr_en    = 1'b1;
                            s_wr_addr  = hit_e_reg;
                            if (new_cnt == '0)
                            begin
                                s_wr_data = '0;
                                scnt_next = scnt_reg - 1'b1;
                            end
                            else
                            begin
                                s_wr_data.valid = 1'b1;
                                s_wr_data.inode = inode_reg;
                                s_wr_data.count = new_cnt;
                            end
                            rsp_next.status          = STAT_OK;
                            rsp_next.sys_index       = 4'(hit_e_reg);
                            rsp_next.user_slot       = 3'(hit_slot_reg);
                            rsp_next.ref_count       = new_cnt;
                            rsp_next.user_open_count = 4'(vcnt_reg - 1'b1);
                            rsp_next.sys_open_count  = 5'(scnt_next);
                        end
                        else
                        begin
                            rsp_next.status = STAT_NOT_OPEN;
                        end
                    end
                end
            end

            ST_SSCAN:
            begin
                if (iss_more)
                begin
                    p1_vld_next = 1'b1;
                    iss_next    = iss_reg + 1'b1;
                end
                if (p1_vld_reg)
                begin
                    if (s_rd_data.valid && s_rd_data.inode == inode_reg && !smatch_reg)
                    begin
                        smatch_next     = 1'b1;
                        smatch_idx_next = SIDX_W'(p1_idx_reg);
                        smatch_cnt_next = s_rd_data.count;
                    end
                    if (!s_rd_data.valid && !sfree_reg)
                    begin
                        sfree_next     = 1'b1;
                        sfree_idx_next = SIDX_W'(p1_idx_reg);
                    end
                end
                if (!iss_more && !p1_vld_reg)
                begin
                    done_next                = 1'b1;
                    state_next               = ST_IDLE;
                    rsp_next.status          = STAT_SYS_FULL;
                    rsp_next.sys_index       = '0;
                    rsp_next.user_slot       = '0;
                    rsp_next.ref_count       = '0;
                    rsp_next.user_open_count = 4'(vcnt_reg);
                    rsp_next.sys_open_count  = 5'(scnt_reg);
                    if (smatch_reg || sfree_reg)
                    begin
                        if (smatch_reg)
                        begin
                            tgt_idx = smatch_idx_reg;
                            new_cnt = (smatch_cnt_reg < COUNT_MAX) ?
                                      smatch_cnt_reg + 1'b1 : smatch_cnt_reg;
                        end
                        else
                        begin
                            tgt_idx   = sfree_idx_reg;
                            new_cnt   = COUNT_W'(1);
                            scnt_next = scnt_reg + 1'b1;
                        end
                        s_wr_en         = 1'b1;
                        s_wr_addr       = tgt_idx;
                        s_wr_data.valid = 1'b1;
                        s_wr_data.inode = inode_reg;
                        s_wr_data.count = new_cnt;
                        u_wr_en         = 1'b1;
                        u_wr_addr       = ubase_reg + UADDR_W'(ufree_slot_reg);
                        u_wr_valid      = 1'b1;
                        u_wr_sidx       = tgt_idx;
                        rsp_next.status          = STAT_OK;
                        rsp_next.sys_index       = 4'(tgt_idx);
                        rsp_next.user_slot       = 3'(ufree_slot_reg);
                        rsp_next.ref_count       = new_cnt;
                        rsp_next.user_open_count = 4'(vcnt_reg + 1'b1);
                        rsp_next.sys_open_count  = 5'(scnt_next);
                    end
                end
            end

            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        s_rd_addr_q    <= s_rd_addr;
        kind_reg       <= kind_next;
        inode_reg      <= inode_next;
        ubase_reg      <= ubase_next;
        p1_idx_reg     <= p1_idx_next;
        p2_slot_reg    <= p2_slot_next;
        p2_uvalid_reg  <= p2_uvalid_next;
        ufree_slot_reg <= ufree_slot_next;
        hit_slot_reg   <= hit_slot_next;
        hit_e_reg      <= hit_e_next;
        hit_cnt_reg    <= hit_cnt_next;
        smatch_idx_reg <= smatch_idx_next;
        smatch_cnt_reg <= smatch_cnt_next;
        sfree_idx_reg  <= sfree_idx_next;
        rsp_reg        <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_INIT;
            iss_reg    <= '0;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            vcnt_reg   <= '0;
            ufree_reg  <= 1'b0;
            hit_reg    <= 1'b0;
            smatch_reg <= 1'b0;
            sfree_reg  <= 1'b0;
            scnt_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            iss_reg    <= iss_next;
            p1_vld_reg <= p1_vld_next;
            p2_vld_reg <= p2_vld_next;
            vcnt_reg   <= vcnt_next;
            ufree_reg  <= ufree_next;
            hit_reg    <= hit_next;
            smatch_reg <= smatch_next;
            sfree_reg  <= sfree_next;
            scnt_reg   <= scnt_next;
            done_reg   <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire
